// File: sv/hrf_pkg.sv
// Shared types and constants for the hart register file and machine CSRs.
`default_nettype none
package hrf_pkg;

  localparam int NUM_GPRS_DEFAULT = 32;
  localparam int XLEN             = 32;
  localparam int CFG_IDX_W        = 2;

  // Operation codes
  localparam logic [2:0] OP_GPR_RD = 3'd0;
  localparam logic [2:0] OP_GPR_WR = 3'd1;
  localparam logic [2:0] OP_CSR_RD = 3'd2;
  localparam logic [2:0] OP_CSR_WR = 3'd3;
  localparam logic [2:0] OP_TRAP   = 3'd4;
  localparam logic [2:0] OP_REINIT = 3'd5;

  // CSR addresses
  localparam logic [11:0] CSRA_STATUS = 12'h300;
  localparam logic [11:0] CSRA_TVEC   = 12'h305;
  localparam logic [11:0] CSRA_EPC    = 12'h341;
  localparam logic [11:0] CSRA_CAUSE  = 12'h342;
  localparam logic [11:0] CSRA_VENDOR = 12'hF11;
  localparam logic [11:0] CSRA_ARCH   = 12'hF12;

  localparam logic [XLEN-1:0] MSTATUS_FIXED = 32'h0000_1800;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BOOT_PC   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VENDOR_ID = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ARCH_ID   = 2'd2;

  typedef struct packed {
    logic [2:0]      op;
    logic [4:0]      reg_index;
    logic [11:0]     csr_addr;
    logic [XLEN-1:0] write_value;
    logic [XLEN-1:0] trap_cause;
    logic [XLEN-1:0] fault_pc;
  } hrf_in_t;

  typedef struct packed {
    logic [XLEN-1:0] read_data;
    logic            addr_ok;
    logic [XLEN-1:0] next_pc;
    logic            next_pc_valid;
  } hrf_out_t;

endpackage
`default_nettype wire

// File: sv/hrf_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module hrf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// File: sv/hart_register_file_and_csrs_top.sv
// Top level: RV32 general registers and machine-mode CSRs.
`default_nettype none
// Architectural state of a minimal RV32 hart. Each input beat carries one
// operation (gpr read/write, csr read/write, trap entry, reinit) and yields
// exactly one output beat. Throughput is one beat per cycle unless out_stall
// holds the output. The RAM read and the stage 1 register load at the accept
// edge; stage 1 then moves into the output register, which raises out_valid.
// out_stall holds the output register and stage 1, and with two beats held
// the input stalls. All state updates and CSR reads happen at the accept
// edge, so a read always sees every earlier write with no interlock. x0 and
// indexes at or above NUM_GPRS read zero and drop writes. The register RAM
// has a valid bit per entry, cleared by reset and by reinit, so no clearing
// pass is needed and an unwritten register reads zero. mstatus is hardwired
// to 0x1800; mtvec and mepc hold bits 31..2 only. Configuration (reset
// vector, vendor and arch IDs) is to be written only while idle, through
// cfg_we/cfg_index/cfg_data; the block itself does not enforce this. Index
// 3 is ignored. Reinit keeps the configuration.
module hart_register_file_and_csrs_top #(
  parameter int NUM_GPRS = hrf_pkg::NUM_GPRS_DEFAULT
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  in_valid,
  output logic                                       in_stall,
  input  wire hrf_pkg::hrf_in_t                      in_item,
  output logic                                       out_valid,
  input  wire logic                                  out_stall,
  output hrf_pkg::hrf_out_t                          out_item,
  input  wire logic                                  cfg_we,
  input  wire logic [hrf_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  wire logic [hrf_pkg::XLEN-1:0]              cfg_data
);
  import hrf_pkg::*;

  localparam int AW = $clog2(NUM_GPRS);

  // configuration
  logic [XLEN-1:0] boot_pc;
  logic [XLEN-1:0] vendor_id;
  logic [XLEN-1:0] arch_id;

  // machine CSRs
  logic [XLEN-3:0] trap_vector;
  logic [XLEN-3:0] saved_pc;
  logic [XLEN-1:0] cause_reg;

  // per-entry written flags for the register RAM
  logic [NUM_GPRS-1:0] gpr_valid;

  // stage 1: RAM read in flight
  logic     s1_valid;
  logic     s1_use_ram;
  hrf_out_t s1_res;
  hrf_out_t s1_out;
  logic     s1_adv;

  logic            accept;
  logic            idx_ok;
  logic [AW-1:0]   gpr_addr;
  logic [XLEN-1:0] ram_rdata;
  logic            ram_we;
  logic            ram_re;
  hrf_out_t        res_next;

  assign s1_adv   = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !s1_adv;
  assign accept   = in_valid && !in_stall;

  assign gpr_addr = in_item.reg_index[AW-1:0];
  assign idx_ok   = (in_item.reg_index != 5'd0) && (int'(in_item.reg_index) < NUM_GPRS);

  assign ram_we = accept && (in_item.op == OP_GPR_WR) && idx_ok;
  assign ram_re = accept && (in_item.op == OP_GPR_RD) && idx_ok;

  hrf_ram #(
    .WIDTH (XLEN),
    .DEPTH (NUM_GPRS)
  ) u_gpr_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (gpr_addr),
    .wdata (in_item.write_value),
    .re    (ram_re),
    .raddr (gpr_addr),
    .rdata (ram_rdata)
  );

  // Result fields known at accept time; gpr read data joins in stage 1.
  always_comb begin
    res_next = '0;
    res_next.addr_ok = 1'b1;
    case (in_item.op)
      OP_CSR_RD: begin
        case (in_item.csr_addr)
          CSRA_VENDOR: res_next.read_data = vendor_id;
          CSRA_ARCH:   res_next.read_data = arch_id;
          CSRA_STATUS: res_next.read_data = MSTATUS_FIXED;
          CSRA_TVEC:   res_next.read_data = {trap_vector, 2'b00};
          CSRA_EPC:    res_next.read_data = {saved_pc, 2'b00};
          CSRA_CAUSE:  res_next.read_data = cause_reg;
          default:     res_next.addr_ok = 1'b0;
        endcase
      end
      OP_CSR_WR: begin
        case (in_item.csr_addr)
          CSRA_VENDOR, CSRA_ARCH, CSRA_STATUS,
          CSRA_TVEC, CSRA_EPC, CSRA_CAUSE: res_next.addr_ok = 1'b1;
          default:                         res_next.addr_ok = 1'b0;
        endcase
      end
      OP_TRAP: begin
        res_next.next_pc       = {trap_vector, 2'b00};
        res_next.next_pc_valid = 1'b1;
      end
      OP_REINIT: begin
        res_next.next_pc       = boot_pc;
        res_next.next_pc_valid = 1'b1;
      end
      default: ;
    endcase
  end

  // stage 1 result with the gpr read data merged in
  always_comb begin
    s1_out = s1_res;
    if (s1_use_ram) begin
      s1_out.read_data = ram_rdata;
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      boot_pc   <= '0;
      vendor_id <= '0;
      arch_id   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BOOT_PC:   boot_pc   <= cfg_data;
        CFG_VENDOR_ID: vendor_id <= cfg_data;
        CFG_ARCH_ID:   arch_id   <= cfg_data;
        default: ;
      endcase
    end
  end

  // architectural state updates at the accept edge
  always_ff @(posedge clk) begin
    if (rst) begin
      trap_vector <= '0;
      saved_pc    <= '0;
      cause_reg   <= '0;
      gpr_valid   <= '0;
    end else if (accept) begin
      case (in_item.op)
        OP_GPR_WR: begin
          if (idx_ok) begin
            gpr_valid[gpr_addr] <= 1'b1;
          end
        end
        OP_CSR_WR: begin
          case (in_item.csr_addr)
            CSRA_TVEC:  trap_vector <= in_item.write_value[XLEN-1:2];
            CSRA_EPC:   saved_pc    <= in_item.write_value[XLEN-1:2];
            CSRA_CAUSE: cause_reg   <= in_item.write_value;
            default: ;
          endcase
        end
        OP_TRAP: begin
          saved_pc  <= in_item.fault_pc[XLEN-1:2];
          cause_reg <= in_item.trap_cause;
        end
        OP_REINIT: begin
          trap_vector <= '0;
          saved_pc    <= '0;
          cause_reg   <= '0;
          gpr_valid   <= '0;
        end
        default: ;
      endcase
    end
  end

  // stage 1 and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_res     <= res_next;
      s1_use_ram <= ram_re && gpr_valid[gpr_addr];
    end
    if (s1_adv) begin
      out_item <= s1_out;
    end
  end

endmodule
`default_nettype wire

// File: tb/hrf_result_checker.sv
`timescale 1ns / 100ps
// Result checker for the hart register file: shadow state, per-beat compare.
module hrf_result_checker #(
  parameter int NUM_GPRS = hrf_pkg::NUM_GPRS_DEFAULT
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  input  wire logic                          in_stall,
  input  wire hrf_pkg::hrf_in_t              in_item,
  input  wire logic                          out_valid,
  input  wire logic                          out_stall,
  input  wire hrf_pkg::hrf_out_t             out_item,
  input  wire logic                          cfg_we,
  input  wire logic [hrf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [hrf_pkg::XLEN-1:0]      cfg_data,
  output int                                 mismatch_count,
  output int                                 results_owed
);
  import hrf_pkg::*;

  // Shadow copy of the hart state.
  logic [XLEN-1:0] gpr_file [32];
  logic [29:0]     mtvec_hi;
  logic [29:0]     mepc_hi;
  logic [XLEN-1:0] mcause_q;
  logic [XLEN-1:0] reset_vec_q;
  logic [XLEN-1:0] vendor_id_q;
  logic [XLEN-1:0] arch_id_q;

  hrf_out_t pending_results [$];

  function automatic void clear_hart_state();
    for (int i = 0; i < 32; i++) gpr_file[i] = '0;
    mtvec_hi = '0;
    mepc_hi  = '0;
    mcause_q = '0;
  endfunction

  // Applies one operation to the shadow state and returns the result beat.
  function automatic hrf_out_t apply_hart_op(hrf_in_t beat);
    hrf_out_t res;
    bit       gpr_live;
    res         = '0;
    res.addr_ok = 1'b1;
    gpr_live    = (beat.reg_index != 5'd0) && (int'(beat.reg_index) < NUM_GPRS);
    case (beat.op)
      OP_GPR_RD: if (gpr_live) res.read_data = gpr_file[beat.reg_index];
      OP_GPR_WR: if (gpr_live) gpr_file[beat.reg_index] = beat.write_value;
      OP_CSR_RD: begin
        case (beat.csr_addr)
          CSRA_VENDOR: res.read_data = vendor_id_q;
          CSRA_ARCH:   res.read_data = arch_id_q;
          CSRA_STATUS: res.read_data = MSTATUS_FIXED;
          CSRA_TVEC:   res.read_data = {mtvec_hi, 2'b00};
          CSRA_EPC:    res.read_data = {mepc_hi, 2'b00};
          CSRA_CAUSE:  res.read_data = mcause_q;
          default:     res.addr_ok = 1'b0;
        endcase
      end
      OP_CSR_WR: begin
        case (beat.csr_addr)
          CSRA_TVEC:  mtvec_hi = beat.write_value[31:2];
          CSRA_EPC:   mepc_hi  = beat.write_value[31:2];
          CSRA_CAUSE: mcause_q = beat.write_value;
          CSRA_STATUS, CSRA_VENDOR, CSRA_ARCH: ;
          default:    res.addr_ok = 1'b0;
        endcase
      end
      OP_TRAP: begin
        mepc_hi           = beat.fault_pc[31:2];
        mcause_q          = beat.trap_cause;
        res.next_pc       = {mtvec_hi, 2'b00};
        res.next_pc_valid = 1'b1;
      end
      OP_REINIT: begin
        clear_hart_state();
        res.next_pc       = reset_vec_q;
        res.next_pc_valid = 1'b1;
      end
      default: ;
    endcase
    return res;
  endfunction

  always @(posedge clk) begin
    hrf_out_t want;
    if (rst) begin
      clear_hart_state();
      reset_vec_q = '0;
      vendor_id_q = '0;
      arch_id_q   = '0;
      pending_results.delete();
      mismatch_count = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          mismatch_count++;
          $display("%0t ns: unexpected result beat, expected none, got %p", $time, out_item);
        end else begin
          want = pending_results.pop_front();
          if (out_item.read_data !== want.read_data) begin
            mismatch_count++;
            $display("%0t ns: read_data expected %h, got %h",
                     $time, want.read_data, out_item.read_data);
          end
          if (out_item.addr_ok !== want.addr_ok) begin
            mismatch_count++;
            $display("%0t ns: addr_ok expected %b, got %b",
                     $time, want.addr_ok, out_item.addr_ok);
          end
          if (out_item.next_pc !== want.next_pc) begin
            mismatch_count++;
            $display("%0t ns: next_pc expected %h, got %h",
                     $time, want.next_pc, out_item.next_pc);
          end
          if (out_item.next_pc_valid !== want.next_pc_valid) begin
            mismatch_count++;
            $display("%0t ns: next_pc_valid expected %b, got %b",
                     $time, want.next_pc_valid, out_item.next_pc_valid);
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_BOOT_PC:   reset_vec_q = cfg_data;
          CFG_VENDOR_ID: vendor_id_q = cfg_data;
          CFG_ARCH_ID:   arch_id_q   = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) pending_results.push_back(apply_hart_op(in_item));
    end
    results_owed = pending_results.size();
  end

endmodule

// File: tb/hart_register_file_and_csrs_top_tb.sv
`timescale 1ns / 100ps
// Testbench top for the hart register file and machine CSRs: stimulus, reset and verdict.
module hart_register_file_and_csrs_top_tb;
  import hrf_pkg::*;

  // Op codes the block does not define; they must leave state alone.
  localparam logic [2:0] OP_UNDEF_LO = 3'd6;
  localparam logic [2:0] OP_UNDEF_HI = 3'd7;
  // Random beats per configuration phase (four phases).
  localparam int PHASE_BEATS = 232;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 in_valid  = 1'b0;
  hrf_in_t              in_item   = '0;
  logic                 out_stall = 1'b0;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [XLEN-1:0]      cfg_data  = '0;
  logic                 in_stall;
  logic                 out_valid;
  hrf_out_t             out_item;
  int                   mismatch_count;
  int                   results_owed;

  // no_gaps: both sides run flat out. hold_request: asks the receiver for
  // one long back-pressure stretch.
  bit no_gaps      = 1'b0;
  bit hold_request = 1'b0;

  hart_register_file_and_csrs_top dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  hrf_result_checker checker_i (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_item        (in_item),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_item       (out_item),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mismatch_count (mismatch_count),
    .results_owed   (results_owed)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #2_000_000;
    $display("FAIL hart_register_file_and_csrs_top");
    $finish;
  end

  // Receiver: random stalls, one long hold-off on request. Drives at negedge.
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = 90;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !no_gaps && ($urandom_range(99) < 31);
      end
    end
  end

  function automatic hrf_in_t op_beat(logic [2:0] op, logic [4:0] idx, logic [11:0] addr,
                                      logic [31:0] wval, logic [31:0] cause,
                                      logic [31:0] pc);
    hrf_in_t b;
    b.op          = op;
    b.reg_index   = idx;
    b.csr_addr    = addr;
    b.write_value = wval;
    b.trap_cause  = cause;
    b.fault_pc    = pc;
    return b;
  endfunction

  // Data words lean toward the all-zero and all-one corners.
  function automatic logic [31:0] rand_word();
    case ($urandom_range(7))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic hrf_in_t rand_beat();
    hrf_in_t b;
    int      pick;
    b = op_beat(OP_GPR_RD, 5'($urandom_range(31)), 12'($urandom_range(4095)),
                rand_word(), rand_word(), rand_word());
    // Implemented CSRs most of the time, any address otherwise.
    case ($urandom_range(7))
      0: b.csr_addr = CSRA_STATUS;
      1: b.csr_addr = CSRA_TVEC;
      2: b.csr_addr = CSRA_EPC;
      3: b.csr_addr = CSRA_CAUSE;
      4: b.csr_addr = CSRA_VENDOR;
      5: b.csr_addr = CSRA_ARCH;
      default: ;
    endcase
    // Reinit kept rare so the register file fills up between clears.
    pick = $urandom_range(99);
    if      (pick < 26) b.op = OP_GPR_RD;
    else if (pick < 48) b.op = OP_GPR_WR;
    else if (pick < 64) b.op = OP_CSR_RD;
    else if (pick < 80) b.op = OP_CSR_WR;
    else if (pick < 91) b.op = OP_TRAP;
    else if (pick < 95) b.op = OP_REINIT;
    else                b.op = $urandom_range(1) ? OP_UNDEF_HI : OP_UNDEF_LO;
    return b;
  endfunction

  // Offers one beat and returns once it is taken. Idle cycles go in front.
  task automatic push_op(input hrf_in_t beat);
    @(negedge clk);
    while (!no_gaps && $urandom_range(99) < 31) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= beat;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Stop offering, wait for every result, then let the pipe settle.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (results_owed != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [XLEN-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Corner configuration for the directed part.
    cfg_write(CFG_BOOT_PC,   32'hFFFF_FFFF);
    cfg_write(CFG_VENDOR_ID, 32'hFFFF_FFFF);
    cfg_write(CFG_ARCH_ID,   32'h0000_0000);

    // Directed: register zero, top register, every CSR, read-only and unknown
    // addresses, misaligned vector data, trap, reinit and undefined ops.
    push_op(op_beat(OP_GPR_RD, 5'd5,  '0, '0, '0, '0));
    push_op(op_beat(OP_GPR_WR, 5'd31, '0, 32'hFFFF_FFFF, '0, '0));
    push_op(op_beat(OP_GPR_WR, 5'd0,  '0, 32'hDEAD_BEEF, '0, '0));
    push_op(op_beat(OP_GPR_RD, 5'd0,  '0, '0, '0, '0));
    push_op(op_beat(OP_GPR_RD, 5'd31, '0, '0, '0, '0));
    push_op(op_beat(OP_GPR_WR, 5'd1,  '0, 32'h0000_0000, '0, '0));
    push_op(op_beat(OP_CSR_WR, '0, CSRA_STATUS, 32'hFFFF_FFFF, '0, '0));
    push_op(op_beat(OP_CSR_RD, '0, CSRA_STATUS, '0, '0, '0));
    push_op(op_beat(OP_CSR_WR, '0, CSRA_TVEC, 32'hFFFF_FFFF, '0, '0));
    push_op(op_beat(OP_CSR_RD, '0, CSRA_TVEC, '0, '0, '0));
    push_op(op_beat(OP_CSR_WR, '0, CSRA_EPC, 32'h0000_0003, '0, '0));
    push_op(op_beat(OP_CSR_RD, '0, CSRA_EPC, '0, '0, '0));
    push_op(op_beat(OP_CSR_WR, '0, CSRA_CAUSE, 32'h8000_0000, '0, '0));
    push_op(op_beat(OP_CSR_WR, '0, CSRA_VENDOR, 32'h1234_5678, '0, '0));
    push_op(op_beat(OP_CSR_RD, '0, CSRA_VENDOR, '0, '0, '0));
    push_op(op_beat(OP_CSR_WR, '0, CSRA_ARCH, 32'hFFFF_FFFF, '0, '0));
    push_op(op_beat(OP_CSR_RD, '0, CSRA_ARCH, '0, '0, '0));
    push_op(op_beat(OP_CSR_WR, '0, 12'h000, 32'hFFFF_FFFF, '0, '0));
    push_op(op_beat(OP_CSR_RD, '0, 12'hFFF, '0, '0, '0));
    push_op(op_beat(OP_TRAP, '0, '0, '0, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    push_op(op_beat(OP_CSR_RD, '0, CSRA_EPC, '0, '0, '0));
    push_op(op_beat(OP_CSR_RD, '0, CSRA_CAUSE, '0, '0, '0));
    push_op(op_beat(OP_REINIT, '0, '0, '0, '0, '0));
    push_op(op_beat(OP_GPR_RD, 5'd31, CSRA_TVEC, '0, '0, '0));
    push_op(op_beat(OP_UNDEF_HI, 5'd31, 12'hFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    push_op(op_beat(OP_UNDEF_LO, 5'd1, CSRA_CAUSE, 32'hFFFF_FFFF, '0, '0));

    // Random phases, each under its own configuration written while idle.
    for (int phase = 0; phase < 4; phase++) begin
      drain();
      case (phase)
        0: begin
          cfg_write(CFG_BOOT_PC,   32'h0000_0000);
          cfg_write(CFG_VENDOR_ID, 32'h0000_0000);
          cfg_write(CFG_ARCH_ID,   32'hFFFF_FFFF);
        end
        default: begin
          cfg_write(CFG_BOOT_PC,   $urandom);
          cfg_write(CFG_VENDOR_ID, $urandom);
          cfg_write(CFG_ARCH_ID,   $urandom);
        end
      endcase
      for (int n = 0; n < PHASE_BEATS; n++) begin
        // Phase 1 carries a gap-free stretch; inside it the receiver holds
        // off long enough for the block to back up and stall its input.
        if (phase == 1) begin
          no_gaps = (n >= 60) && (n < 200);
          if (n == 80) hold_request = 1'b1;
        end
        push_op(rand_beat());
      end
      no_gaps = 1'b0;
    end

    drain();
    if (mismatch_count == 0 && results_owed == 0) begin
      $display("PASS hart_register_file_and_csrs_top");
    end else begin
      $display("FAIL hart_register_file_and_csrs_top");
    end
    $finish;
  end

endmodule

// File: files.f
sv/hrf_pkg.sv
sv/hrf_ram.sv
sv/hart_register_file_and_csrs_top.sv
tb/hrf_result_checker.sv
tb/hart_register_file_and_csrs_top_tb.sv
